@@ design/pmcr_pkg.sv @@
// Shared types and constants for the pattern match, count and remove block.
`timescale 1ns / 1ps

package pmcr_pkg;

   localparam int BYTE_W    = 8;
   localparam int TOTAL_W   = 20;
   localparam int LEN_CFG_W = 6;
   localparam int WORD_W    = 64;
   localparam int PAT_WORDS = 4;
   localparam int PAT_BYTES = 32;
   localparam int PAT_IDX_W = 5;
   localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH     = 3'd0,
      CSR_PATTERN_WORD_ZERO  = 3'd1,
      CSR_PATTERN_WORD_ONE   = 3'd2,
      CSR_PATTERN_WORD_TWO   = 3'd3,
      CSR_PATTERN_WORD_THREE = 3'd4,
      CSR_OPERATING_MODE     = 3'd5
   } csr_index_type;

   typedef enum logic {
      MODE_COUNT  = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_MATCH,
      ST_FLUSH,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic               result_kind;
      logic [BYTE_W-1:0]  kept_byte;
      logic [TOTAL_W-1:0] match_total;
      logic               final_result;
   } rsp_payload_type;

   // window control from the sequencer
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] shift_byte;
   } win_ctrl_type;

   // window status back to the sequencer
   typedef struct packed {
      logic              all_hit;
      logic [BYTE_W-1:0] read_byte;
   } win_status_type;

endpackage

@@ design/pmcr_cell.sv @@
// One window cell: holds a text byte, passes it on, compares it with its pattern byte.
`timescale 1ns / 1ps

module pmcr_cell (
   input  logic                      clock,
   input  logic                      shift,
   input  logic [pmcr_pkg::BYTE_W-1:0] prev_byte,
   input  logic [pmcr_pkg::BYTE_W-1:0] expected_byte,
   output logic [pmcr_pkg::BYTE_W-1:0] cell_byte,
   output logic                      hit
);
   import pmcr_pkg::*;

   logic [BYTE_W-1:0] window_byte_ff;
   logic [BYTE_W-1:0] window_byte_in;

   assign window_byte_in = shift ? prev_byte : window_byte_ff;

   always_ff @(posedge clock) begin
      window_byte_ff <= window_byte_in;
   end

   assign cell_byte = window_byte_ff;
   assign hit       = (window_byte_ff == expected_byte);

endmodule

@@ design/pmcr_window.sv @@
// Shift window built as a row of cells, with match reduction and oldest-byte readout.
`timescale 1ns / 1ps

module pmcr_window #(
   parameter int PATTERN_MAX = 32,
   parameter int FILL_W      = $clog2(PATTERN_MAX + 1),
   parameter int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  logic                         clock,
   input  pmcr_pkg::win_ctrl_type       ctrl,
   input  logic [FILL_W-1:0]            len,
   input  logic [pmcr_pkg::BYTE_W-1:0]  pat_bytes [pmcr_pkg::PAT_BYTES],
   input  logic [IDX_W-1:0]             read_idx,
   output pmcr_pkg::win_status_type     status
);
   import pmcr_pkg::*;

   logic [BYTE_W-1:0]    cell_bytes [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hits;
   logic [PATTERN_MAX-1:0] in_use;
   logic [PAT_IDX_W:0]   len_wide;

   assign len_wide = (PAT_IDX_W + 1)'(len);

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [BYTE_W-1:0]    prev_byte;
      logic [BYTE_W-1:0]    expected_byte;
      logic [PAT_IDX_W-1:0] pat_idx;

      // cell j lines up with pattern byte len-1-j
      assign pat_idx       = PAT_IDX_W'(len_wide - (PAT_IDX_W + 1)'(j + 1));
      assign expected_byte = pat_bytes[pat_idx];
      assign in_use[j]     = ((PAT_IDX_W + 1)'(j) < len_wide);

      if (j == 0) begin : g_head
         assign prev_byte = ctrl.shift_byte;
      end else begin : g_link
         assign prev_byte = cell_bytes[j-1];
      end

      pmcr_cell u_cell (
         .clock         (clock),
         .shift         (ctrl.shift),
         .prev_byte     (prev_byte),
         .expected_byte (expected_byte),
         .cell_byte     (cell_bytes[j]),
         .hit           (hits[j])
      );
   end

   assign status.all_hit   = &(hits | ~in_use);
   assign status.read_byte = cell_bytes[read_idx];

endmodule

@@ design/pattern_match_count_remove_top.sv @@
// Top level: configuration registers, item sequencer, window and result register.
`timescale 1ns / 1ps

// Pattern search over a byte stream, counting or removing matches.
// Text bytes arrive on the req_ channel (valid/stall), one transfer per byte,
// end_of_text marking the final byte. Results leave on the rsp_ channel
// (valid/stall) from a single output register, so a result may wait there
// while the sequencer carries on with the next step.
// The csr_ channel writes the pattern length, four pattern words and the mode;
// csr_ready is always high; writes are to be made only while the block is
// idle, and the block itself does not enforce this. Count mode: every
// occurrence, overlapping ones too, is counted; only the report leaves the
// block. Remove mode: bytes that can no longer begin a match are emitted
// oldest first, a completed match empties the window.
// A byte takes an evict/shift step, then a compare step, plus an evict step
// per byte evicted ahead of it; the pace is set by the window shift and the
// compare across the row of cells. On end of text, a flush step per flushed
// byte and then the report follow. Results are registered before rsp_.
// Reset (synchronous, active high) empties the window, clears the count and
// restores the registers to length one, zero pattern, count mode.
// While rsp_stall is high the held result stays put and the sequencer waits
// at the next step that needs the output register; req_stall rises meanwhile.

module pattern_match_count_remove_top #(
   parameter int PATTERN_MAX = 32,
   parameter int COUNT_BITS  = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pmcr_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pmcr_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pmcr_pkg::WORD_W-1:0]       csr_data
);
   import pmcr_pkg::*;

   localparam int FILL_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX);

   // configuration registers
   logic [LEN_CFG_W-1:0] pattern_length_ff;
   logic [WORD_W-1:0]    pattern_words_ff [PAT_WORDS];
   mode_type             mode_ff;

   // sequencer state
   state_type            state_ff, state_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic [BYTE_W-1:0]    pat_bytes [PAT_BYTES];
   logic [FILL_W-1:0]    len_eff;
   logic                 removing;
   logic                 out_free;
   logic                 accept;
   logic                 evict_need;
   logic                 flush_need;
   logic [FILL_W-1:0]    fill_less;
   logic [IDX_W-1:0]     read_idx;
   logic [COUNT_BITS+TOTAL_W-1:0] count_wide;
   win_ctrl_type         win_ctrl;
   win_status_type       win_status;

   assign csr_ready = 1'b1;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_CFG_W'(1);
         for (int w = 0; w < PAT_WORDS; w++) begin
            pattern_words_ff[w] <= '0;
         end
         mode_ff <= MODE_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH:     pattern_length_ff   <= csr_data[LEN_CFG_W-1:0];
            CSR_PATTERN_WORD_ZERO:  pattern_words_ff[0] <= csr_data;
            CSR_PATTERN_WORD_ONE:   pattern_words_ff[1] <= csr_data;
            CSR_PATTERN_WORD_TWO:   pattern_words_ff[2] <= csr_data;
            CSR_PATTERN_WORD_THREE: pattern_words_ff[3] <= csr_data;
            CSR_OPERATING_MODE:     mode_ff <= mode_type'(csr_data[0]);
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < PAT_BYTES; k++) begin : g_pat
      assign pat_bytes[k] =
         pattern_words_ff[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
   end

   // length zero acts as one, anything past the window acts as the window size
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if ({1'b0, pattern_length_ff} > (LEN_CFG_W + 1)'(PATTERN_MAX)) begin
         len_eff = FILL_MAX;
      end else begin
         len_eff = FILL_W'(pattern_length_ff);
      end
   end

   assign removing   = (mode_ff == MODE_REMOVE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_MATCH) && !last_ff));
   assign accept     = req_valid && !req_stall;
   assign evict_need = removing && (fill_ff >= len_eff);
   assign flush_need = removing && (fill_ff != '0);
   assign fill_less  = fill_ff - FILL_W'(1);
   assign read_idx   = fill_less[IDX_W-1:0];
   assign count_wide = {TOTAL_W'(0), count_ff};

   pmcr_window #(
      .PATTERN_MAX (PATTERN_MAX),
      .FILL_W      (FILL_W),
      .IDX_W       (IDX_W)
   ) u_window (
      .clock     (clock),
      .ctrl      (win_ctrl),
      .len       (len_eff),
      .pat_bytes (pat_bytes),
      .read_idx  (read_idx),
      .status    (win_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (!evict_need) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            priority if (last_ff) state_in = ST_FLUSH;
            else if (accept) state_in = ST_EVICT;
            else state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (!flush_need) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      win_ctrl.shift      = 1'b0;
      win_ctrl.shift_byte = byte_ff;

      if (accept) begin
         byte_in = req_data.text_byte;
         last_in = req_data.end_of_text;
      end

      unique case (state_ff)
         ST_IDLE: ;
         ST_EVICT: begin
            if (evict_need) begin
               if (out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.result_kind  = KIND_DATA;
                  rsp_data_in.kept_byte    = win_status.read_byte;
                  rsp_data_in.match_total  = '0;
                  rsp_data_in.final_result = 1'b0;
                  fill_in                  = fill_less;
               end
            end else begin
               win_ctrl.shift = 1'b1;
               if (fill_ff != FILL_MAX) fill_in = fill_ff + FILL_W'(1);
            end
         end
         ST_MATCH: begin
            if ((fill_ff >= len_eff) && win_status.all_hit) begin
               if (count_ff != '1) count_in = count_ff + COUNT_BITS'(1);
               if (removing) fill_in = '0;
            end
         end
         ST_FLUSH: begin
            if (flush_need && out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_kind  = KIND_DATA;
               rsp_data_in.kept_byte    = win_status.read_byte;
               rsp_data_in.match_total  = '0;
               rsp_data_in.final_result = 1'b0;
               fill_in                  = fill_less;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_kind  = KIND_REPORT;
               rsp_data_in.kept_byte    = '0;
               rsp_data_in.match_total  = count_wide[TOTAL_W-1:0];
               rsp_data_in.final_result = 1'b1;
               fill_in                  = '0;
               count_in                 = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/pattern_match_count_remove_top_test.sv @@
// Self-checking testbench for the pattern match, count and remove block.
`timescale 1ns / 1ps

// Text bytes are queued by the stimulus process and handed to the req_ channel
// by a bursty sender. Each accepted byte goes through a cycle-free model of the
// search. The model yields the kept bytes and the count report that the rsp_
// channel must carry, in order.
// The receiver stalls on patterns of its own. Once, it holds off for a long
// stretch so that the output register fills and req_stall rises.
// Registers are only written once the block has drained and settled.

module pattern_match_count_remove_top_test;
   import pmcr_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int PATTERN_MAX   = 32;
   localparam int COUNT_BITS    = 20;
   localparam int TARGET_BYTES  = 430;
   // a full eviction, a full flush and the report, with margin
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD     = 400;
   // slowest run: about 450 bytes, each with up to 34 results behind heavy
   // stalls and the longest sender gap, plus the settle pauses; kept well over
   localparam int RUN_LIMIT_NS  = 10_000_000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data  = '0;

   // search state as the block should hold it; starts at the reset values
   logic [LEN_CFG_W-1:0] cfg_len  = 6'd1;
   logic [WORD_W-1:0]    cfg_word [PAT_WORDS];
   mode_type             cfg_mode = MODE_COUNT;
   logic [BYTE_W-1:0]    window_bytes [PATTERN_MAX];
   int unsigned          window_count = 0;
   int unsigned          hit_count    = 0;

   rsp_payload_type results_due [$];
   req_payload_type text_to_send [$];

   // handshake bookkeeping
   int unsigned req_transfers = 0;
   int unsigned req_handed    = 0;
   int unsigned burst_left    = 0;
   int unsigned gap_left      = 0;
   int unsigned hold_asked    = 0;
   int unsigned hold_given    = 0;
   int unsigned hold_left     = 0;
   int unsigned style_left    = 0;
   stall_style_type stall_style = STALL_NONE;

   // stimulus shaping
   logic [BYTE_W-1:0] alpha_base = 8'h61;
   int unsigned       alpha_span = 3;
   bit                text_open  = 1'b0;

   // run statistics
   int unsigned bytes_queued    = 0;
   int unsigned texts_closed    = 0;
   int unsigned kept_checked    = 0;
   int unsigned reports_checked = 0;
   int unsigned matches_found   = 0;
   int unsigned csr_writes      = 0;
   int unsigned phases_run      = 0;
   int unsigned mismatches      = 0;

   pattern_match_count_remove_top #(
      .PATTERN_MAX (PATTERN_MAX),
      .COUNT_BITS  (COUNT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- model

   // zero reads as one and anything above the window size as the window size
   function automatic int unsigned effective_length();
      int unsigned n;
      n = 32'(cfg_len);
      if (n == 0) begin
         n = 1;
      end
      if (n > PATTERN_MAX) begin
         n = PATTERN_MAX;
      end
      return n;
   endfunction

   // pattern byte k, in text order
   function automatic logic [BYTE_W-1:0] pattern_byte_at(int unsigned k);
      return cfg_word[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
   endfunction

   function automatic void queue_result(kind_type kind, logic [BYTE_W-1:0] kept,
                                        logic [TOTAL_W-1:0] total);
      rsp_payload_type r;
      r.result_kind  = kind;
      r.kept_byte    = kept;
      r.match_total  = total;
      r.final_result = (kind == KIND_REPORT);
      results_due.push_back(r);
   endfunction

   // one text byte through the search; window entry 0 is the newest
   function automatic void predict_search_step(req_payload_type item);
      int unsigned len;
      int          i;
      bit          removing;
      bit          hit;
      len      = effective_length();
      removing = (cfg_mode == MODE_REMOVE);
      // bytes that can no longer start a match leave oldest first
      if (removing) begin
         while (window_count >= len) begin
            queue_result(KIND_DATA, window_bytes[window_count - 1], '0);
            window_count--;
         end
      end
      for (i = PATTERN_MAX - 1; i > 0; i--) begin
         window_bytes[i] = window_bytes[i - 1];
      end
      window_bytes[0] = item.text_byte;
      if (window_count < PATTERN_MAX) begin
         window_count++;
      end
      hit = (window_count >= len);
      for (i = 0; i < len; i++) begin
         if (window_bytes[i] != pattern_byte_at(len - 1 - i)) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         matches_found++;
         if (hit_count < (1 << COUNT_BITS) - 1) begin
            hit_count++;
         end
         // a removed match leaves nothing behind to overlap with
         if (removing) begin
            window_count = 0;
         end
      end
      if (item.end_of_text) begin
         if (removing) begin
            while (window_count > 0) begin
               queue_result(KIND_DATA, window_bytes[window_count - 1], '0);
               window_count--;
            end
         end
         queue_result(KIND_REPORT, '0, TOTAL_W'(hit_count));
         window_count = 0;
         hit_count    = 0;
         texts_closed++;
      end
   endfunction

   function automatic void report_mismatch(string what, rsp_payload_type want,
                                           rsp_payload_type got);
      mismatches++;
      // fields in order: kind / kept byte / total / final
      if (mismatches <= 10) begin
         $display("[%0t] %s: want %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d", $time, what,
                  want.result_kind, want.kept_byte, want.match_total, want.final_result,
                  got.result_kind, got.kept_byte, got.match_total, got.final_result);
      end
   endfunction

   // ---------------------------------------------- transfers at the rising edge

   // prediction first, so the order against the check never matters
   always @(posedge clock) begin : transfer_monitor
      rsp_payload_type want;
      string           what;
      if (!reset && req_valid && !req_stall) begin
         predict_search_step(req_data);
         req_transfers++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing expected", '0, rsp_data);
         end else begin
            want = results_due.pop_front();
            what = "";
            if (rsp_data.result_kind !== want.result_kind) begin
               what = {what, " kind"};
            end
            if (rsp_data.kept_byte !== want.kept_byte) begin
               what = {what, " kept_byte"};
            end
            if (rsp_data.match_total !== want.match_total) begin
               what = {what, " match_total"};
            end
            if (rsp_data.final_result !== want.final_result) begin
               what = {what, " final_result"};
            end
            if (what != "") begin
               report_mismatch({"mismatch in", what}, want, rsp_data);
            end
            if (want.result_kind == KIND_REPORT) begin
               reports_checked++;
            end else begin
               kept_checked++;
            end
         end
      end
   end

   // ------------------------------------------- driving at the falling edge

   // Sender: bursts of random length with random gaps. A byte on offer stays
   // put until its transfer has been seen.
   always @(negedge clock) begin : text_sender
      logic            next_valid;
      req_payload_type next_item;
      next_valid = req_valid;
      next_item  = req_data;
      if (req_valid && req_transfers != req_handed) begin
         req_handed = req_transfers;
         next_valid = 1'b0;
      end
      if (!next_valid && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (text_to_send.size() > 0) begin
            next_item  = text_to_send.pop_front();
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_item;
   end

   // Receiver: switches stall style at random intervals; a requested long
   // hold-off is counted out here.
   always @(negedge clock) begin : result_receiver
      logic next_stall;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (hold_asked != hold_given) begin
         hold_given++;
         hold_left  = LONG_HOLD - 1;
         next_stall = 1'b1;
      end else begin
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left  = $urandom_range(8, 80);
         end else begin
            style_left--;
         end
         case (stall_style)
            STALL_NONE: begin
               next_stall = 1'b0;
            end
            STALL_LIGHT: begin
               next_stall = ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               next_stall = ($urandom_range(0, 3) != 0);
            end
            default: begin
               next_stall = !rsp_stall;
            end
         endcase
      end
      rsp_stall <= next_stall;
   end

   // ------------------------------------------------------- stimulus helpers

   task automatic write_csr(csr_index_type idx, logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PATTERN_LENGTH: begin
            cfg_len = value[LEN_CFG_W-1:0];
         end
         CSR_PATTERN_WORD_ZERO: begin
            cfg_word[0] = value;
         end
         CSR_PATTERN_WORD_ONE: begin
            cfg_word[1] = value;
         end
         CSR_PATTERN_WORD_TWO: begin
            cfg_word[2] = value;
         end
         CSR_PATTERN_WORD_THREE: begin
            cfg_word[3] = value;
         end
         CSR_OPERATING_MODE: begin
            cfg_mode = mode_type'(value[0]);
         end
         default: begin
         end
      endcase
      csr_writes++;
   endtask

   task automatic apply_config(logic [LEN_CFG_W-1:0] len, logic [WORD_W-1:0] w0,
                               logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2,
                               logic [WORD_W-1:0] w3, mode_type mode);
      write_csr(CSR_PATTERN_LENGTH, WORD_W'(len));
      write_csr(CSR_PATTERN_WORD_ZERO, w0);
      write_csr(CSR_PATTERN_WORD_ONE, w1);
      write_csr(CSR_PATTERN_WORD_TWO, w2);
      write_csr(CSR_PATTERN_WORD_THREE, w3);
      write_csr(CSR_OPERATING_MODE, WORD_W'(mode));
      phases_run++;
   endtask

   // every queued byte transferred and every expected result back
   task automatic wait_drained();
      do @(negedge clock);
      while (text_to_send.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   // count mode bytes give no result, so the block may still be busy: let it settle
   task automatic wait_settled();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void push_byte(logic [BYTE_W-1:0] b, bit last);
      req_payload_type item;
      item.text_byte   = b;
      item.end_of_text = last;
      text_to_send.push_back(item);
      bytes_queued++;
   endfunction

   function automatic logic [BYTE_W-1:0] alpha_byte();
      return alpha_base + BYTE_W'($urandom_range(0, alpha_span - 1));
   endfunction

   function automatic logic [WORD_W-1:0] random_pattern_word();
      logic [WORD_W-1:0] w;
      int unsigned       sel;
      int                k;
      sel = $urandom_range(0, 19);
      if (sel < 4) begin
         w = {$urandom, $urandom};
      end else if (sel == 4) begin
         w = '1;
      end else if (sel == 5) begin
         w = '0;
      end else begin
         for (k = 0; k < BYTES_PER_WORD; k++) begin
            w[k * BYTE_W +: BYTE_W] = alpha_byte();
         end
      end
      return w;
   endfunction

   // Mostly whole pattern copies and near misses in a small alphabet, so
   // matches, overlaps and partial matches are common; the rest is noise.
   task automatic push_text(int unsigned n_bytes, bit close_text);
      int unsigned       len;
      int unsigned       made;
      int unsigned       roll;
      int unsigned       cut;
      int unsigned       k;
      logic [BYTE_W-1:0] b;
      len  = effective_length();
      made = 0;
      while (made < n_bytes) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            cut = (roll < 28) ? len : $urandom_range(1, len);
            for (k = 0; k < cut && made < n_bytes; k++) begin
               b = pattern_byte_at(k);
               if (roll >= 28 && k == cut - 1) begin
                  b = b ^ (8'h01 << $urandom_range(0, 7));
               end
               push_byte(b, close_text && made == n_bytes - 1);
               made++;
            end
         end else begin
            b = ($urandom_range(0, 1) == 0) ? alpha_byte() : BYTE_W'($urandom_range(0, 255));
            push_byte(b, close_text && made == n_bytes - 1);
            made++;
         end
      end
      text_open = !close_text;
   endtask

   // ------------------------------------------------------------- the run

   initial begin : stimulus
      int unsigned             k;
      int unsigned             texts;
      int unsigned             roll;
      logic [LEN_CFG_W-1:0]    len_pick;
      mode_type                mode_pick;
      for (k = 0; k < PAT_WORDS; k++) begin
         cfg_word[k] = '0;
      end
      for (k = 0; k < PATTERN_MAX; k++) begin
         window_bytes[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: length one, zero pattern, count mode; extreme byte values
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      wait_settled();

      // length zero behaves as length one
      apply_config(6'd0, 64'hFF, '0, '0, '0, MODE_COUNT);
      push_byte(8'hFF, 1'b1);
      wait_settled();

      // overlapping occurrences are all counted
      apply_config(6'd2, 64'h4141, '0, '0, '0, MODE_COUNT);
      repeat (3) push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b1);
      wait_settled();

      // removal takes non-overlapping occurrences, leftmost first
      apply_config(6'd2, 64'h4141, '0, '0, '0, MODE_REMOVE);
      repeat (4) push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b1);
      wait_settled();

      // longest field value, clipped to the window; the text is too short to match
      apply_config(6'd63, '1, '1, '1, '1, MODE_REMOVE);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b1);
      wait_settled();

      // put six bytes into the window in count mode, then shrink the pattern and
      // switch to removal: the next byte pushes several old bytes out ahead of it
      apply_config(6'd40, 64'h5A5A5A5A5A5A5A5A, '0, '0, '0, MODE_COUNT);
      for (k = 0; k < 6; k++) begin
         push_byte(8'h30 + BYTE_W'(k), 1'b0);
      end
      wait_settled();
      apply_config(6'd2, 64'h3534, '0, '0, '0, MODE_REMOVE);
      push_byte(8'h36, 1'b1);
      wait_settled();

      // random phases; the first one carries the long receiver hold-off and a
      // sender pause mid-stream
      while (bytes_queued < TARGET_BYTES) begin
         alpha_base = BYTE_W'($urandom_range(0, 255));
         alpha_span = $urandom_range(1, 4);
         roll       = $urandom_range(0, 99);
         if (roll < 65) begin
            len_pick = LEN_CFG_W'($urandom_range(1, 6));
         end else if (roll < 85) begin
            len_pick = LEN_CFG_W'($urandom_range(7, 32));
         end else begin
            case ($urandom_range(0, 4))
               0: len_pick = 6'd0;
               1: len_pick = 6'd1;
               2: len_pick = 6'd32;
               3: len_pick = 6'd33;
               default: len_pick = 6'd63;
            endcase
         end
         mode_pick = mode_type'($urandom_range(0, 1));
         if (hold_asked == 0) begin
            apply_config(6'd3, random_pattern_word(), random_pattern_word(),
                         random_pattern_word(), random_pattern_word(), MODE_REMOVE);
            hold_asked++;
            push_text(30, 1'b1);
            wait_drained();
            push_text(30, 1'b1);
         end else begin
            apply_config(len_pick, random_pattern_word(), random_pattern_word(),
                         random_pattern_word(), random_pattern_word(), mode_pick);
            texts = $urandom_range(1, 3);
            for (k = 0; k < texts; k++) begin
               push_text($urandom_range(1, 2 * effective_length() + 10),
                         (k < texts - 1) || ($urandom_range(0, 4) != 0));
               if ($urandom_range(0, 5) == 0) begin
                  wait_drained();
               end
            end
         end
         wait_settled();
      end
      if (text_open) begin
         push_byte(alpha_byte(), 1'b1);
      end
      wait_settled();

      if (results_due.size() != 0) begin
         $display("%0d expected results never arrived", results_due.size());
         mismatches += results_due.size();
      end
      $display("Sent %0d text bytes in %0d texts over %0d settings (%0d register writes).",
               bytes_queued, texts_closed, phases_run, csr_writes);
      $display("Checked %0d kept bytes and %0d count reports; %0d matches seen, %0d errors.",
               kept_checked, reports_checked, matches_found, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Timed out waiting for the block");
      $display("Test completed with failures");
      $finish;
   end

endmodule
